@@ rtl/lru_key_value_cache_top_defines.svh @@
// Assertion macros shared by the LRU key-value cache RTL.
// Uses the clock and reset names common to every module of the block.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lkvc_pkg.sv @@
// Package for the LRU key-value cache: field widths, codes, FSM and command types.
// No dependencies; imported by every other file of the block except the assertion macro header.
`default_nettype none

package lkvc_pkg;

   // payload widths
   localparam int KEY_W  = 31;
   localparam int VAL_W  = 32;
   localparam int CAP_W  = 5;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // capacity register reset value
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register indexes
   localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;

   // opcodes
   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_SELECT,
      ST_COMMIT
   } state_type;

   // how the chosen entry is updated
   typedef enum logic [1:0] {
      MODE_HIT,
      MODE_FILL,
      MODE_REPLACE
   } mode_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic match;
      logic select;
      logic commit;
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/lkvc_channels.sv @@
// Handshake channel interfaces for request and response transfers.
// Depends on lkvc_pkg for payload widths.
`default_nettype none

interface lkvc_req_if;
   import lkvc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic [KEY_W-1:0]        key;
   logic signed [VAL_W-1:0] value_in;

   modport source (output valid, output opcode, output key, output value_in, input ready);
   modport sink   (input valid, input opcode, input key, input value_in, output ready);
endinterface

interface lkvc_rsp_if;
   import lkvc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    hit;
   logic signed [VAL_W-1:0] value_out;

   modport source (output valid, output hit, output value_out, input ready);
   modport sink   (input valid, input hit, input value_out, output ready);
endinterface

`default_nettype wire

@@ rtl/lkvc_csr.sv @@
// APB-style register port holding the capacity register.
// Depends on lkvc_pkg.
`default_nettype none

module lkvc_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [lkvc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [lkvc_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [lkvc_pkg::DATA_W-1:0] csr_prdata,
   output logic                             csr_pready,
   output logic      [lkvc_pkg::CAP_W-1:0]  capacity
);
   import lkvc_pkg::*;

   logic [CAP_W-1:0]  capacity_ff;
   logic [CAP_W-1:0]  capacity_in;
   logic [ADDR_W-3:0] reg_index;
   logic              wr_en;

   assign reg_index  = csr_paddr[ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write, other indexes ignored
   always_comb begin
      capacity_in = capacity_ff;
      if (wr_en && reg_index == REG_CAPACITY) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // read-back
   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_CAPACITY) begin
         csr_prdata = DATA_W'(capacity_ff);
      end
   end

   assign capacity = capacity_ff;

endmodule

`default_nettype wire

@@ rtl/lkvc_ctrl.sv @@
// Controller FSM: sequences accept, match, select and commit for each request.
// Depends on lkvc_pkg and the assertion macro header.
`default_nettype none
`include "lru_key_value_cache_top_defines.svh"

module lkvc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output lkvc_pkg::cmd_type      cmd
);
   import lkvc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            cmd.match = 1'b1;
            state_in  = ST_SELECT;
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_COMMIT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // output valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `LKVC_ASSERT_NEXT(a_accept_starts_match, req_valid && req_ready, state_ff == ST_MATCH, "accepted request did not start lookup")
   `LKVC_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_valid_ff, "committed result not presented")

endmodule

`default_nettype wire

@@ rtl/lkvc_dpath.sv @@
// Datapath: entry storage, associative key match, LRU age ranks, output register.
// Depends on lkvc_pkg and the assertion macro header.
`default_nettype none
`include "lru_key_value_cache_top_defines.svh"

module lkvc_dpath #(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lkvc_pkg::cmd_type                 cmd,
   input  wire logic [lkvc_pkg::CAP_W-1:0]        capacity,
   input  wire logic                              req_opcode,
   input  wire logic [lkvc_pkg::KEY_W-1:0]        req_key,
   input  wire logic signed [lkvc_pkg::VAL_W-1:0] req_value_in,
   output logic                                   rsp_hit,
   output logic signed [lkvc_pkg::VAL_W-1:0]      rsp_value_out
);
   import lkvc_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

   // request hold registers
   logic                    op_ff;
   logic [KEY_W-1:0]        key_ff;
   logic signed [VAL_W-1:0] val_ff;

   // entry storage
   logic [KEY_W-1:0]  entry_key_ff   [NUM_SLOTS];
   logic [VAL_W-1:0]  entry_value_ff [NUM_SLOTS];
   logic [SLOT_W-1:0] rank_ff        [NUM_SLOTS];
   logic [SLOT_W-1:0] rank_in        [NUM_SLOTS];
   logic [CNT_W-1:0]  fill_count_ff;
   logic [CNT_W-1:0]  fill_count_in;

   // pipeline of the lookup
   logic [NUM_SLOTS-1:0] match_ff;
   logic [NUM_SLOTS-1:0] match_in;
   logic [NUM_SLOTS-1:0] oldest_vec;
   logic                 found_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    slot_in;
   mode_type             mode_ff;
   mode_type             mode_in;
   logic [CNT_W-1:0]     rank_ref_ff;
   logic [CNT_W-1:0]     rank_ref_in;
   logic [SLOT_W-1:0]    hit_slot;
   logic [SLOT_W-1:0]    oldest_slot;
   logic [CAP_W-1:0]     eff_cap;
   logic                 full;
   logic                 touch;

   // output register
   logic                    rsp_hit_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic signed [VAL_W-1:0] rsp_value_in;

   // capture the request
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         val_ff <= req_value_in;
      end
   end

   // associative compare against filled entries
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         match_in[i] = (entry_key_ff[i] == key_ff) && (CNT_W'(i) < fill_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         match_ff <= match_in;
      end
   end

   // lowest matching slot, and the entry with the oldest rank
   always_comb begin
      hit_slot    = '0;
      oldest_slot = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         oldest_vec[i] = (CNT_W'(i) < fill_count_ff) &&
                         (CNT_W'(rank_ff[i]) == fill_count_ff - 1'b1);
         if (match_ff[i]) begin
            hit_slot = SLOT_W'(i);
         end
         if (oldest_vec[i]) begin
            oldest_slot = SLOT_W'(i);
         end
      end
   end

   // effective capacity, clamped to one and to the slot count
   always_comb begin
      eff_cap = capacity;
      if (capacity == '0) begin
         eff_cap = CAP_W'(1);
      end else if (capacity > CAP_W'(NUM_SLOTS)) begin
         eff_cap = CAP_W'(NUM_SLOTS);
      end
   end

   assign full = CAP_W'(fill_count_ff) >= eff_cap;

   // choose slot, update mode and the rank threshold for aging
   always_comb begin
      if (|match_ff) begin
         mode_in     = MODE_HIT;
         slot_in     = hit_slot;
         rank_ref_in = CNT_W'(rank_ff[hit_slot]);
      end else if (!full) begin
         mode_in     = MODE_FILL;
         slot_in     = fill_count_ff[SLOT_W-1:0];
         rank_ref_in = fill_count_ff;
      end else begin
         mode_in     = MODE_REPLACE;
         slot_in     = oldest_slot;
         rank_ref_in = fill_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.select) begin
         found_ff    <= |match_ff;
         slot_ff     <= slot_in;
         mode_ff     <= mode_in;
         rank_ref_ff <= rank_ref_in;
      end
   end

   // a get hit or any set makes the slot most recent
   assign touch = cmd.commit && (found_ff || op_ff == OP_SET);

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         rank_in[i] = rank_ff[i];
         if (touch) begin
            if (SLOT_W'(i) == slot_ff) begin
               rank_in[i] = '0;
            end else if (CNT_W'(i) < fill_count_ff &&
                         CNT_W'(rank_ff[i]) < rank_ref_ff) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      if (cmd.commit && op_ff == OP_SET && mode_ff == MODE_FILL) begin
         fill_count_in = fill_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         fill_count_ff <= fill_count_in;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // entry write on set
   always_ff @(posedge clock) begin
      if (cmd.commit && op_ff == OP_SET) begin
         entry_key_ff[slot_ff]   <= key_ff;
         entry_value_ff[slot_ff] <= val_ff;
      end
   end

   // result value
   always_comb begin
      if (op_ff == OP_SET) begin
         rsp_value_in = val_ff;
      end else if (found_ff) begin
         rsp_value_in = entry_value_ff[slot_ff];
      end else begin
         rsp_value_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff   <= found_ff;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_hit       = rsp_hit_ff;
   assign rsp_value_out = rsp_value_ff;

   `LKVC_ASSERT_SAME(a_fill_bound, 1'b1, fill_count_ff <= CNT_W'(NUM_SLOTS), "fill count above slot count")
   `LKVC_ASSERT_SAME(a_oldest_unique, fill_count_ff != '0, $onehot(oldest_vec), "age ranks not a permutation")
   `LKVC_ASSERT_NEXT(a_fill_grows, touch && mode_ff == MODE_FILL, fill_count_ff == CNT_W'($past(fill_count_ff) + 1'b1), "fill did not grow the store")

endmodule

`default_nettype wire

@@ rtl/lru_key_value_cache_top.sv @@
// An accepted request passes through key match, slot select and commit, then its result is
// registered in the output register. A new request is taken only once the previous one has
// committed, set by the serial match/select/commit sequence; commit waits on a held result.
// A new request is taken while the previous result still waits in the output register.
// Reset: store empty, all age ranks zero, capacity 16; no clearing pass, ready right away.
// Depends on lkvc_pkg, lkvc_channels, lkvc_csr, lkvc_ctrl and lkvc_dpath.
`default_nettype none

module lru_key_value_cache_top #(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   lkvc_req_if.sink                         req_if,
   lkvc_rsp_if.source                       rsp_if,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [lkvc_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [lkvc_pkg::DATA_W-1:0] csr_pwdata,
   output logic      [lkvc_pkg::DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import lkvc_pkg::*;

   // capacity never exceeds 31, so slots beyond that are never used
   localparam int NUM_SLOTS = (MAX_ENTRIES < 31) ? MAX_ENTRIES : 31;

   cmd_type                 cmd;
   logic [CAP_W-1:0]        capacity;
   logic                    req_ready;
   logic                    rsp_valid;
   logic                    rsp_hit;
   logic signed [VAL_W-1:0] rsp_value_out;

   lkvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   lkvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   lkvc_dpath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .capacity      (capacity),
      .req_opcode    (req_if.opcode),
      .req_key       (req_if.key),
      .req_value_in  (req_if.value_in),
      .rsp_hit       (rsp_hit),
      .rsp_value_out (rsp_value_out)
   );

   // channel hookup
   assign req_if.ready     = req_ready;
   assign rsp_if.valid     = rsp_valid;
   assign rsp_if.hit       = rsp_hit;
   assign rsp_if.value_out = rsp_value_out;

endmodule

`default_nettype wire
